// File: hdl/dfbs_pkg.sv
`timescale 1ns / 1ps

package dfbs_pkg;

  localparam int DEF_FRAME_DEPTH  = 2048;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int CFG_W       = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] FRAME_LEN_RESET = 12'd1024;
  localparam logic [CFG_W-1:0] PREAMBLE_RESET  = 12'd144;

  // register select is paddr[2]
  localparam logic REG_FRAME_LEN = 1'b0;
  localparam logic REG_PREAMBLE  = 1'b1;

  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_PRIMARY = 2'd1;
  localparam logic [1:0] KIND_HYBRID  = 2'd2;

  typedef enum logic [1:0] {
    OP_PRI_WRITE = 2'd0,
    OP_SEC_WRITE = 2'd1,
    OP_SLOT      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRIMARY = 2'd1,
    MODE_HYBRID  = 2'd2
  } mode_t;

  // result control carried from front to back
  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [1:0] kind;
    logic       last;
    logic       rd;
    logic       add;
  } cmd_t;

endpackage

// File: hdl/dfbs_front.sv
`timescale 1ns / 1ps

module dfbs_front #(
  parameter int FRAME_DEPTH  = dfbs_pkg::DEF_FRAME_DEPTH,
  parameter int SAMPLE_WIDTH = dfbs_pkg::DEF_SAMPLE_WIDTH,
  parameter int TDATA_W      = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [TDATA_W-1:0]              s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic [dfbs_pkg::CFG_W-1:0]      frame_length,
  input  logic [dfbs_pkg::CFG_W-1:0]      preamble_length,
  input  logic [dfbs_pkg::QCNT_W-1:0]     q_count,
  output logic                            push,
  output dfbs_pkg::cmd_t                  push_cmd,
  output logic [4*SAMPLE_WIDTH-1:0]       push_data
);

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam int LEN_W = IDX_W + 1;
  localparam int SMP_W = 2 * SAMPLE_WIDTH;

  logic [SMP_W-1:0] pri_mem [FRAME_DEPTH];
  logic [SMP_W-1:0] sec_mem [FRAME_DEPTH];
  logic [SMP_W-1:0] pri_q, sec_q;

  logic [IDX_W-1:0] pwidx, pwidx_next;
  logic [IDX_W-1:0] swidx, swidx_next;
  logic [IDX_W-1:0] ridx, ridx_next;
  logic             pfull, pfull_next;
  logic             sfull, sfull_next;
  dfbs_pkg::mode_t  mode, mode_next;

  logic             s1_valid;
  dfbs_pkg::cmd_t   s1_cmd;
  dfbs_pkg::cmd_t   cmd;

  logic             fire;
  logic             pri_we, sec_we, rd_en;
  dfbs_pkg::op_t    op;
  logic [31:0]      flen32;
  logic [LEN_W-1:0] len;
  logic [SMP_W-1:0] sample;

  assign sample = s_tdata[SMP_W-1:0];
  assign op     = dfbs_pkg::op_t'(s_tuser);

  // zero counts as one, anything beyond the store depth is clipped
  assign flen32 = 32'(frame_length);
  always_comb begin
    if (flen32 == 32'd0) begin
      len = LEN_W'(1);
    end else if (flen32 > 32'(FRAME_DEPTH)) begin
      len = LEN_W'(FRAME_DEPTH);
    end else begin
      len = LEN_W'(flen32);
    end
  end

  // leave room for the word in flight in the read stage
  assign s_tready = (32'(q_count) + 32'(s1_valid)) < 32'(dfbs_pkg::QUEUE_DEPTH);
  assign fire     = s_tvalid & s_tready;

  always_comb begin
    pwidx_next = pwidx;
    swidx_next = swidx;
    ridx_next  = ridx;
    pfull_next = pfull;
    sfull_next = sfull;
    mode_next  = mode;
    cmd        = '0;
    pri_we     = 1'b0;
    sec_we     = 1'b0;
    rd_en      = 1'b0;
    if (fire) begin
      unique case (op)
        dfbs_pkg::OP_PRI_WRITE: begin
          if (!pfull) begin
            pri_we       = 1'b1;
            cmd.accepted = 1'b1;
            if (LEN_W'(pwidx) + LEN_W'(1) >= len) begin
              pwidx_next = '0;
              pfull_next = 1'b1;
            end else begin
              pwidx_next = pwidx + IDX_W'(1);
            end
          end
        end
        dfbs_pkg::OP_SEC_WRITE: begin
          if (!sfull) begin
            sec_we       = 1'b1;
            cmd.accepted = 1'b1;
            if (LEN_W'(swidx) + LEN_W'(1) >= len) begin
              swidx_next = '0;
              sfull_next = 1'b1;
            end else begin
              swidx_next = swidx + IDX_W'(1);
            end
          end
        end
        dfbs_pkg::OP_SLOT: begin
          cmd.out_valid = 1'b1;
          unique case (mode)
            dfbs_pkg::MODE_IDLE: begin
              // send a zero word, then pick the frame type
              if (pfull) begin
                mode_next = sfull ? dfbs_pkg::MODE_HYBRID : dfbs_pkg::MODE_PRIMARY;
              end
              ridx_next = '0;
            end
            dfbs_pkg::MODE_PRIMARY, dfbs_pkg::MODE_HYBRID: begin
              rd_en  = 1'b1;
              cmd.rd = 1'b1;
              if (mode == dfbs_pkg::MODE_HYBRID) begin
                cmd.kind = dfbs_pkg::KIND_HYBRID;
                cmd.add  = (32'(ridx) >= 32'(preamble_length));
              end else begin
                cmd.kind = dfbs_pkg::KIND_PRIMARY;
              end
              if (LEN_W'(ridx) + LEN_W'(1) >= len) begin
                cmd.last   = 1'b1;
                ridx_next  = '0;
                pfull_next = 1'b0;
                pwidx_next = '0;
                if (mode == dfbs_pkg::MODE_HYBRID) begin
                  sfull_next = 1'b0;
                  swidx_next = '0;
                end
                mode_next = dfbs_pkg::MODE_IDLE;
              end else begin
                ridx_next = ridx + IDX_W'(1);
              end
            end
            default: begin
              mode_next = dfbs_pkg::MODE_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwidx    <= '0;
      swidx    <= '0;
      ridx     <= '0;
      pfull    <= 1'b0;
      sfull    <= 1'b0;
      mode     <= dfbs_pkg::MODE_IDLE;
      s1_valid <= 1'b0;
    end else begin
      pwidx    <= pwidx_next;
      swidx    <= swidx_next;
      ridx     <= ridx_next;
      pfull    <= pfull_next;
      sfull    <= sfull_next;
      mode     <= mode_next;
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd <= cmd;
  end

  always_ff @(posedge clk) begin
    if (pri_we) begin
      pri_mem[pwidx] <= sample;
    end
    if (rd_en) begin
      pri_q <= pri_mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (sec_we) begin
      sec_mem[swidx] <= sample;
    end
    if (rd_en) begin
      sec_q <= sec_mem[ridx];
    end
  end

  assign push      = s1_valid;
  assign push_cmd  = s1_cmd;
  assign push_data = s1_cmd.rd ? {sec_q, pri_q} : '0;

endmodule

// File: hdl/dfbs_queue.sv
`timescale 1ns / 1ps

module dfbs_queue #(
  parameter int WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [WIDTH-1:0]            push_word,
  input  logic                        pop,
  output logic                        head_valid,
  output logic [WIDTH-1:0]            head_word,
  output logic [dfbs_pkg::QCNT_W-1:0] count
);

  localparam int PTR_W = $clog2(dfbs_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [dfbs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign head_valid = (count != '0);
  assign head_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + dfbs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - dfbs_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

// File: hdl/dfbs_back.sv
`timescale 1ns / 1ps

module dfbs_back #(
  parameter int SAMPLE_WIDTH = dfbs_pkg::DEF_SAMPLE_WIDTH,
  parameter int TDATA_W      = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  dfbs_pkg::cmd_t            head_cmd,
  input  logic [4*SAMPLE_WIDTH-1:0] head_data,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [TDATA_W-1:0]        m_tdata,
  output logic [3:0]                m_tuser,
  output logic                      m_tlast
);

  localparam int SW = SAMPLE_WIDTH;

  logic [SW-1:0] pri_re, pri_im, sec_re, sec_im;
  logic [SW-1:0] sum_re, sum_im, res_re, res_im;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_add = s[SW-1:0];
    end
  endfunction

  assign pri_re = head_data[SW-1:0];
  assign pri_im = head_data[2*SW-1:SW];
  assign sec_re = head_data[3*SW-1:2*SW];
  assign sec_im = head_data[4*SW-1:3*SW];

  assign sum_re = sat_add(pri_re, sec_re);
  assign sum_im = sat_add(pri_im, sec_im);
  assign res_re = head_cmd.add ? sum_re : pri_re;
  assign res_im = head_cmd.add ? sum_im : pri_im;

  // advance whenever the output register is empty or being drained
  assign pop = head_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= TDATA_W'({res_im, res_re});
      m_tuser <= {head_cmd.kind, head_cmd.out_valid, head_cmd.accepted};
      m_tlast <= head_cmd.last;
    end
  end

endmodule

// File: hdl/dual_frame_buffer_superpose.sv
`timescale 1ns / 1ps

// Dual frame buffer with superposition.
// Input stream: s_tuser carries the op (primary write, secondary write,
// output slot request), s_tdata the complex sample. Every accepted word
// gives exactly one result word on the output stream: write results say
// whether the sample was stored (refused while that store holds an unsent
// full frame); slot results carry an idle zero, a primary frame sample or a
// hybrid sample (primary alone during the preamble, then the saturated sum).
// Words go from the read stage of the two frame RAMs through a 4-entry
// queue to the output register; one word is taken every cycle while
// s_tready is high.
// s_tready drops once the queued words plus the word in the read stage fill
// the four entries, so a stalled receiver holds the output word and backs up
// the input after a few words.
// Reset clears indices, full flags and the emit mode, and sets frame_length
// to 1024 and preamble_length to 144; store contents are not cleared.
// Registers: frame_length at 0x0, preamble_length at 0x4 (12 bits each).
module dual_frame_buffer_superpose #(
  parameter int FRAME_DEPTH  = dfbs_pkg::DEF_FRAME_DEPTH,
  parameter int SAMPLE_WIDTH = dfbs_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // sample_re, sample_im
  input  logic [1:0]                             s_tuser,  // op
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,  // out_re, out_im
  output logic [3:0]                             m_tuser,  // accepted, out_valid, out_kind
  output logic                                   m_tlast,  // frame_last
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int DATA_W  = 4 * SAMPLE_WIDTH;
  localparam int QWORD_W = $bits(dfbs_pkg::cmd_t) + DATA_W;

  logic [dfbs_pkg::CFG_W-1:0]  frame_length, preamble_length;
  logic                        cfg_we;

  logic                        push, pop, head_valid;
  dfbs_pkg::cmd_t              push_cmd, head_cmd;
  logic [DATA_W-1:0]           push_data, head_data;
  logic [QWORD_W-1:0]          head_word;
  logic [dfbs_pkg::QCNT_W-1:0] q_count;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length    <= dfbs_pkg::FRAME_LEN_RESET;
      preamble_length <= dfbs_pkg::PREAMBLE_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == dfbs_pkg::REG_FRAME_LEN) begin
        frame_length <= pwdata[dfbs_pkg::CFG_W-1:0];
      end else begin
        preamble_length <= pwdata[dfbs_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      dfbs_pkg::REG_FRAME_LEN: prdata = 32'(frame_length);
      dfbs_pkg::REG_PREAMBLE:  prdata = 32'(preamble_length);
      default:                 prdata = '0;
    endcase
  end

  dfbs_front #(
    .FRAME_DEPTH  (FRAME_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (TDATA_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .frame_length    (frame_length),
    .preamble_length (preamble_length),
    .q_count         (q_count),
    .push            (push),
    .push_cmd        (push_cmd),
    .push_data       (push_data)
  );

  dfbs_queue #(
    .WIDTH (QWORD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  ({push_cmd, push_data}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word),
    .count      (q_count)
  );

  assign head_cmd  = dfbs_pkg::cmd_t'(head_word[QWORD_W-1:DATA_W]);
  assign head_data = head_word[DATA_W-1:0];

  dfbs_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (TDATA_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
